>>> src/sdio_frame_header_engine_unit_assert.svh
`ifndef SDIO_FRAME_HEADER_ENGINE_UNIT_ASSERT_SVH
`define SDIO_FRAME_HEADER_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SFHE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFHE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/sfhe_pkg.sv
package sfhe_pkg;

  localparam logic [15:0] HDR_LEN       = 16'd12;
  localparam logic [3:0]  HDR_LAST      = 4'd11;
  localparam logic [15:0] MAX_FRAME_RST = 16'd2048;

  localparam logic CMD_RX = 1'b0;
  localparam logic CMD_TX = 1'b1;

  localparam logic [1:0] KIND_RX_DATA   = 2'd0;
  localparam logic [1:0] KIND_RX_STATUS = 2'd1;
  localparam logic [1:0] KIND_TX_HDR    = 2'd2;
  localparam logic [1:0] KIND_TX_STATUS = 2'd3;

  localparam logic [1:0] CH_CONTROL = 2'd0;
  localparam logic [1:0] CH_EVENT   = 2'd1;
  localparam logic [1:0] CH_DATA    = 2'd2;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_NO_DATA     = 4'd1;
  localparam logic [3:0] ST_BAD_HEADER  = 4'd2;
  localparam logic [3:0] ST_BAD_OFFSET  = 4'd3;
  localparam logic [3:0] ST_TOO_LARGE   = 4'd4;
  localparam logic [3:0] ST_EMPTY_EVENT = 4'd5;
  localparam logic [3:0] ST_BAD_CHANNEL = 4'd6;
  localparam logic [3:0] ST_NO_CREDIT   = 4'd7;
  localparam logic [3:0] ST_FLOW_UPDATE = 4'd8;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  rx_byte;
    logic [15:0] tx_length;
    logic [7:0]  tx_offset;
    logic        tx_control;
  } req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] channel;
    logic       last;
    logic [3:0] status;
    logic [7:0] seq;
  } rsp_t;

  // Header byte at a given position of an outgoing frame.
  function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [15:0] len,
                                          input logic [7:0] seq, input logic [1:0] chan,
                                          input logic [7:0] off);
    logic [15:0] inv;
    logic [7:0]  b;
    inv = ~len;
    case (idx)
      4'd0:    b = len[7:0];
      4'd1:    b = len[15:8];
      4'd2:    b = inv[7:0];
      4'd3:    b = inv[15:8];
      4'd4:    b = seq;
      4'd5:    b = {6'd0, chan};
      4'd7:    b = off;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

>>> src/sfhe_req_if.sv
interface sfhe_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  rx_byte;
  logic [15:0] tx_length;
  logic [7:0]  tx_offset;
  logic        tx_control;

  modport source (output valid, cmd, rx_byte, tx_length, tx_offset, tx_control,
                  input ready);
  modport sink (input valid, cmd, rx_byte, tx_length, tx_offset, tx_control,
                output ready);
endinterface

>>> src/sfhe_rsp_if.sv
interface sfhe_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [1:0] out_channel;
  logic       out_last;
  logic [3:0] out_status;
  logic [7:0] out_seq;

  modport source (output valid, out_kind, out_byte, out_channel, out_last, out_status,
                  out_seq, input ready);
  modport sink (input valid, out_kind, out_byte, out_channel, out_last, out_status,
                out_seq, output ready);
endinterface

>>> src/sfhe_cfg_if.sv
interface sfhe_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_frame_len;

  modport source (output valid, max_frame_len, input ready);
  modport sink (input valid, max_frame_len, output ready);
endinterface

>>> src/sfhe_rx_parser.sv
`include "sdio_frame_header_engine_unit_assert.svh"

module sfhe_rx_parser import sfhe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] max_frame_len,
  output logic [7:0]  credit_limit,
  output logic        emit,
  output rsp_t        res
);

  logic [15:0] pos, pos_next;
  logic [15:0] size, size_next;
  logic [7:0]  check_lo, check_lo_next;
  logic [3:0]  chan, chan_next;
  logic [7:0]  offset, offset_next;
  logic [3:0]  pend, pend_next;
  logic [7:0]  credit, credit_next;
  logic [1:0]  chan_out;
  logic        offset_ok;
  logic        last;

  assign chan_out     = (chan <= 4'd2) ? chan[1:0] : CH_CONTROL;
  assign offset_ok    = ({8'd0, offset} >= HDR_LEN) && ({8'd0, offset} <= size);
  assign last         = (pos == size - 16'd1);
  assign credit_limit = credit;

  always_comb begin
    pos_next      = pos;
    size_next     = size;
    check_lo_next = check_lo;
    chan_next     = chan;
    offset_next   = offset;
    pend_next     = pend;
    credit_next   = credit;
    emit          = 1'b0;
    res           = '0;
    if (pos >= HDR_LEN) begin
      if (pend == ST_OK && pos >= {8'd0, offset}) begin
        emit        = 1'b1;
        res.kind    = KIND_RX_DATA;
        res.data    = rx_byte;
        res.channel = chan_out;
        res.last    = last;
        res.status  = ST_OK;
      end else if (last) begin
        emit        = 1'b1;
        res.kind    = KIND_RX_STATUS;
        res.channel = chan_out;
        res.last    = 1'b1;
        res.status  = pend;
      end
      pos_next = last ? 16'd0 : pos + 16'd1;
    end else begin
      pos_next = pos + 16'd1;
      case (pos[3:0])
        4'd0: size_next = {8'd0, rx_byte};
        4'd1: size_next = {rx_byte, size[7:0]};
        4'd2: check_lo_next = rx_byte;
        4'd3: begin
          if (size == 16'd0) begin
            emit       = 1'b1;
            res.kind   = KIND_RX_STATUS;
            res.last   = 1'b1;
            res.status = ST_NO_DATA;
            pos_next   = 16'd0;
          end else if ({rx_byte, check_lo} != ~size || size < HDR_LEN) begin
            emit       = 1'b1;
            res.kind   = KIND_RX_STATUS;
            res.last   = 1'b1;
            res.status = ST_BAD_HEADER;
            pos_next   = 16'd0;
          end
        end
        4'd5: chan_next = rx_byte[3:0];
        4'd7: offset_next = rx_byte;
        4'd9: begin
          // Fix the frame status and take the credit if the offset holds.
          if (size == HDR_LEN) begin
            if (offset_ok) begin
              credit_next = rx_byte;
              pend_next   = ST_FLOW_UPDATE;
            end else begin
              pend_next = ST_BAD_OFFSET;
            end
          end else if (size > max_frame_len) begin
            pend_next = ST_TOO_LARGE;
          end else if (!offset_ok) begin
            pend_next = ST_BAD_OFFSET;
          end else begin
            credit_next = rx_byte;
            if (chan > 4'd2) begin
              pend_next = ST_BAD_CHANNEL;
            end else if (chan[1:0] == CH_EVENT && {8'd0, offset} == size) begin
              pend_next = ST_EMPTY_EVENT;
            end else begin
              pend_next = ST_OK;
            end
          end
        end
        4'd11: begin
          if (size == HDR_LEN) begin
            emit        = 1'b1;
            res.kind    = KIND_RX_STATUS;
            res.channel = chan_out;
            res.last    = 1'b1;
            res.status  = pend;
            pos_next    = 16'd0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      size     <= '0;
      check_lo <= '0;
      chan     <= '0;
      offset   <= '0;
      pend     <= '0;
      credit   <= '0;
    end else if (fire) begin
      pos      <= pos_next;
      size     <= size_next;
      check_lo <= check_lo_next;
      chan     <= chan_next;
      offset   <= offset_next;
      pend     <= pend_next;
      credit   <= credit_next;
    end
  end

  `SFHE_ASSERT_NOW(a_rx_payload_in_frame, clk, rst, pos >= HDR_LEN, size > HDR_LEN && pos < size, "rx position past frame end")

endmodule

>>> src/sfhe_tx_framer.sv
`include "sdio_frame_header_engine_unit_assert.svh"

module sfhe_tx_framer import sfhe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic [15:0] tx_length,
  input  logic [7:0]  tx_offset,
  input  logic        tx_control,
  input  logic [7:0]  credit_limit,
  output logic        done,
  output logic        busy,
  output rsp_t        res
);

  logic [7:0] seq;
  logic [3:0] idx;
  logic [1:0] chan;
  logic       no_credit;
  logic       wrap;

  assign chan      = tx_control ? CH_CONTROL : CH_DATA;
  assign no_credit = (seq == credit_limit);
  assign wrap      = fire && !no_credit && idx == HDR_LAST;
  assign busy      = (idx != 4'd0);

  always_comb begin
    res.channel = chan;
    res.seq     = seq;
    if (no_credit) begin
      res.kind   = KIND_TX_STATUS;
      res.data   = 8'd0;
      res.last   = 1'b1;
      res.status = ST_NO_CREDIT;
      done       = 1'b1;
    end else begin
      res.kind   = KIND_TX_HDR;
      res.data   = hdr_byte(idx, tx_length, seq, chan, tx_offset);
      res.last   = (idx == HDR_LAST);
      res.status = ST_OK;
      done       = (idx == HDR_LAST);
    end
  end

  // One header byte per fired cycle with credit; bump seq after the last.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= '0;
      idx <= '0;
    end else if (fire && !no_credit) begin
      if (idx == HDR_LAST) begin
        idx <= '0;
        seq <= seq + 8'd1;
      end else begin
        idx <= idx + 4'd1;
      end
    end
  end

  `SFHE_ASSERT_NOW(a_tx_idx_range, clk, rst, 1'b1, idx <= HDR_LAST, "tx header index out of range")
  `SFHE_ASSERT_NOW(a_tx_seq_step, clk, rst, !$past(rst) && seq != $past(seq), $past(wrap) && seq == $past(seq) + 8'd1, "tx sequence moved without a finished header")

endmodule

>>> src/sdio_frame_header_engine_unit.sv
// Frame header engine for an SDIO packet link.
// req (sink): one item per handshake; cmd 0 carries a received stream byte,
//   cmd 1 asks for the 12-byte header of an outgoing frame.
// rsp (source): result items; received payload bytes tagged with their
//   channel, status-only frame-end items, header bytes or no_credit items.
// cfg (sink): writes max_frame_len; always ready, write only while idle.
// Path: an accepted item goes through the input register, then the result
//   register.
// Throughput: one received byte per cycle while rsp does not stall. A
//   transmit request holds the input register while the header counter
//   walks the bytes in; a no_credit request gives a single status item.
// Reset clears the parser position, frame state, credit, sequence and the
//   valid bits; max_frame_len returns to 2048.
// When rsp stalls, the result register holds its item and the input
//   register one more; req.ready drops when both are full or mid-header.
`include "sdio_frame_header_engine_unit_assert.svh"

module sdio_frame_header_engine_unit import sfhe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sfhe_cfg_if.sink   cfg,
  sfhe_req_if.sink   req,
  sfhe_rsp_if.source rsp
);

  logic        v1;
  req_t        s1;
  logic        ov;
  rsp_t        orsp;
  logic [15:0] max_frame_len;
  logic        out_free;
  logic        fire;
  logic        rx_fire;
  logic        tx_fire;
  logic        item_done;
  logic        emit;
  rsp_t        sel;
  logic [7:0]  credit_limit;
  logic        rx_emit;
  rsp_t        rx_res;
  logic        tx_done;
  logic        tx_busy;
  rsp_t        tx_res;

  assign out_free  = !ov || rsp.ready;
  assign fire      = v1 && out_free;
  assign rx_fire   = fire && s1.cmd == CMD_RX;
  assign tx_fire   = fire && s1.cmd == CMD_TX;
  assign item_done = (s1.cmd == CMD_RX) ? 1'b1 : tx_done;
  assign emit      = (s1.cmd == CMD_RX) ? rx_emit : 1'b1;
  assign sel       = (s1.cmd == CMD_RX) ? rx_res : tx_res;
  assign req.ready = !v1 || (fire && item_done);
  assign cfg.ready = 1'b1;

  sfhe_rx_parser u_rx (
    .clk          (clk),
    .rst          (rst),
    .fire         (rx_fire),
    .rx_byte      (s1.rx_byte),
    .max_frame_len(max_frame_len),
    .credit_limit (credit_limit),
    .emit         (rx_emit),
    .res          (rx_res)
  );

  sfhe_tx_framer u_tx (
    .clk         (clk),
    .rst         (rst),
    .fire        (tx_fire),
    .tx_length   (s1.tx_length),
    .tx_offset   (s1.tx_offset),
    .tx_control  (s1.tx_control),
    .credit_limit(credit_limit),
    .done        (tx_done),
    .busy        (tx_busy),
    .res         (tx_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= MAX_FRAME_RST;
    end else if (cfg.valid && cfg.ready) begin
      max_frame_len <= cfg.max_frame_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (req.ready) begin
      v1 <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1 <= '{cmd: req.cmd, rx_byte: req.rx_byte, tx_length: req.tx_length,
              tx_offset: req.tx_offset, tx_control: req.tx_control};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (out_free) begin
      ov <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      orsp <= sel;
    end
  end

  assign rsp.valid       = ov;
  assign rsp.out_kind    = orsp.kind;
  assign rsp.out_byte    = orsp.data;
  assign rsp.out_channel = orsp.channel;
  assign rsp.out_last    = orsp.last;
  assign rsp.out_status  = orsp.status;
  assign rsp.out_seq     = orsp.seq;

  `SFHE_ASSERT_NOW(a_tx_busy_holds_item, clk, rst, tx_busy, v1 && s1.cmd == CMD_TX, "header in progress without a transmit item")

endmodule
